>>> rtl/lms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lms_pkg
// Types, constants and helper functions of the lid motor sequencer.
// ----------------------------------------------------------------------------
package lms_pkg;

    // Width of the tick counters; counters saturate at their top value
    localparam int TICK_WIDTH = 16;
    localparam int LEN_WIDTH  = 16;
    localparam int CMP_WIDTH  = (TICK_WIDTH > LEN_WIDTH) ? TICK_WIDTH : LEN_WIDTH;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int LEVEL_WIDTH     = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_TICKS    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RUN_TIMEOUT    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOUNCE_TICKS   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STOP_TICKS     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_IDLE_TIMEOUT   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BATTERY_LOW    = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALARM_ON_TICKS = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALARM_OFF      = 3'd7;

    // Register reset values
    localparam logic [LEN_WIDTH-1:0]   RST_START_TICKS    = 16'd100;
    localparam logic [LEN_WIDTH-1:0]   RST_RUN_TIMEOUT    = 16'd350;
    localparam logic [LEN_WIDTH-1:0]   RST_BOUNCE_TICKS   = 16'd180;
    localparam logic [LEN_WIDTH-1:0]   RST_STOP_TICKS     = 16'd500;
    localparam logic [LEN_WIDTH-1:0]   RST_IDLE_TIMEOUT   = 16'd800;
    localparam logic [LEVEL_WIDTH-1:0] RST_BATTERY_LOW    = 8'd237;
    localparam logic [LEN_WIDTH-1:0]   RST_ALARM_ON_TICKS = 16'd50;
    localparam logic [LEN_WIDTH-1:0]   RST_ALARM_OFF      = 16'd500;

    // Samples below this floor never count as a low battery
    localparam logic [LEVEL_WIDTH-1:0] BATTERY_FLOOR = 8'd5;

    // Motor drive codes
    localparam logic [1:0] DRIVE_OFF   = 2'd0;
    localparam logic [1:0] DRIVE_OPEN  = 2'd1;
    localparam logic [1:0] DRIVE_CLOSE = 2'd2;

    typedef enum logic [3:0] {
        PH_POWERUP   = 4'd0,
        PH_IDLE      = 4'd1,
        PH_SLEEP     = 4'd2,
        PH_START     = 4'd3,
        PH_RUN       = 4'd4,
        PH_BOUNCE    = 4'd5,
        PH_STOP      = 4'd6,
        PH_ALARM_ON  = 4'd7,
        PH_ALARM_OFF = 4'd8
    } phase_t;

    typedef struct packed {
        logic [LEN_WIDTH-1:0]   start_ticks;
        logic [LEN_WIDTH-1:0]   run_timeout_ticks;
        logic [LEN_WIDTH-1:0]   bounce_ticks;
        logic [LEN_WIDTH-1:0]   stop_ticks;
        logic [LEN_WIDTH-1:0]   idle_timeout_ticks;
        logic [LEVEL_WIDTH-1:0] battery_low_level;
        logic [LEN_WIDTH-1:0]   alarm_on_ticks;
        logic [LEN_WIDTH-1:0]   alarm_off_ticks;
    } cfg_t;

    // Outcome of walking through the timed phases of a move in one tick
    typedef struct packed {
        logic                  finished;
        phase_t                phase;
        logic [TICK_WIDTH-1:0] count;
        logic [1:0]            drive;
    } walk_t;

    // A count has reached a length, or is saturated
    function automatic logic reached(input logic [TICK_WIDTH-1:0] count,
                                     input logic [LEN_WIDTH-1:0] len);
        return (CMP_WIDTH'(count) >= CMP_WIDTH'(len)) || (count == TICK_MAX);
    endfunction

    // Saturating increment
    function automatic logic [TICK_WIDTH-1:0] bump(input logic [TICK_WIDTH-1:0] count);
        return (count == TICK_MAX) ? count : count + TICK_WIDTH'(1);
    endfunction

    // Walk start, run, reverse pulse and pause; a reached phase hands over at once
    function automatic walk_t walk(input phase_t ph,
                                   input logic [TICK_WIDTH-1:0] count,
                                   input logic opening,
                                   input logic limit,
                                   input cfg_t cfg);
        walk_t      w;
        logic [1:0] fwd;
        logic [1:0] rev;
        fwd        = opening ? DRIVE_OPEN : DRIVE_CLOSE;
        rev        = opening ? DRIVE_CLOSE : DRIVE_OPEN;
        w.finished = 1'b0;
        w.phase    = ph;
        w.count    = count;
        w.drive    = DRIVE_OFF;
        if (w.phase == PH_START && reached(w.count, cfg.start_ticks))
        begin
            w.phase = PH_RUN;
            w.count = '0;
        end
        if (w.phase == PH_RUN && (limit || reached(w.count, cfg.run_timeout_ticks)))
        begin
            w.phase = PH_BOUNCE;
            w.count = '0;
        end
        if (w.phase == PH_BOUNCE && reached(w.count, cfg.bounce_ticks))
        begin
            w.phase = PH_STOP;
            w.count = '0;
        end
        if (w.phase == PH_STOP && reached(w.count, cfg.stop_ticks))
        begin
            w.finished = 1'b1;
            w.count    = '0;
        end
        else
        begin
            if (w.phase == PH_BOUNCE)
            begin
                w.drive = rev;
            end
            else if (w.phase != PH_STOP)
            begin
                w.drive = fwd;
            end
            w.count = bump(w.count);
        end
        return w;
    endfunction

endpackage
`default_nettype wire

>>> rtl/lid_motor_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lid_motor_sequencer
// Tick driven lid motor controller: toggle moves, sleep and battery alarm.
// ----------------------------------------------------------------------------
// Each input word is one time tick and yields exactly one result word that
// describes the state after that tick. The block takes one word per clock
// cycle while the output is not stalled: a word is captured in an input
// register, and the whole tick (all phase hand-overs of that tick included)
// is resolved by logic between that register and the result register, which
// holds the result word at the output.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while the block holds no word in flight.
// ----------------------------------------------------------------------------
module lid_motor_sequencer
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        button_pressed,
    input  wire logic        limit_reached,
    input  wire logic [7:0]  battery_level,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       motor_drive,
    output logic             lid_closed,
    output logic             asleep,
    output logic             battery_alarm,

    input  wire logic        cfg_we,
    input  wire logic [lms_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [lms_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    // Configuration
    lms_pkg::cfg_t cfg_reg;

    // Input stage
    logic                              in_valid_reg;
    logic                              btn_reg;
    logic                              lim_reg;
    logic [lms_pkg::LEVEL_WIDTH-1:0]   level_reg;

    // Sequencer state
    lms_pkg::phase_t                   phase_reg,   phase_next;
    logic [lms_pkg::TICK_WIDTH-1:0]    count_reg,   count_next;
    logic [lms_pkg::TICK_WIDTH-1:0]    idle_reg,    idle_next;
    logic                              closed_reg,  closed_next;
    logic                              opening_reg, opening_next;
    logic                              btn_prev_reg;
    logic                              sam_reg,     sam_next;
    logic [1:0]                        drive_next;

    // Output stage
    logic                              out_valid_reg;
    logic [1:0]                        drive_reg;
    logic                              closed_out_reg;
    logic                              asleep_reg;
    logic                              alarm_reg;

    logic advance;
    logic load;

    // Handshake: the tick resolves when the result register is free
    assign advance  = ~out_valid_reg | ~out_stall;
    assign load     = ~in_valid_reg | advance;
    assign in_stall = in_valid_reg & ~advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_ticks        <= lms_pkg::RST_START_TICKS;
            cfg_reg.run_timeout_ticks  <= lms_pkg::RST_RUN_TIMEOUT;
            cfg_reg.bounce_ticks       <= lms_pkg::RST_BOUNCE_TICKS;
            cfg_reg.stop_ticks         <= lms_pkg::RST_STOP_TICKS;
            cfg_reg.idle_timeout_ticks <= lms_pkg::RST_IDLE_TIMEOUT;
            cfg_reg.battery_low_level  <= lms_pkg::RST_BATTERY_LOW;
            cfg_reg.alarm_on_ticks     <= lms_pkg::RST_ALARM_ON_TICKS;
            cfg_reg.alarm_off_ticks    <= lms_pkg::RST_ALARM_OFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lms_pkg::REG_START_TICKS:    cfg_reg.start_ticks        <= cfg_data;
                lms_pkg::REG_RUN_TIMEOUT:    cfg_reg.run_timeout_ticks  <= cfg_data;
                lms_pkg::REG_BOUNCE_TICKS:   cfg_reg.bounce_ticks       <= cfg_data;
                lms_pkg::REG_STOP_TICKS:     cfg_reg.stop_ticks         <= cfg_data;
                lms_pkg::REG_IDLE_TIMEOUT:   cfg_reg.idle_timeout_ticks <= cfg_data;
                lms_pkg::REG_BATTERY_LOW:
                    cfg_reg.battery_low_level <= cfg_data[lms_pkg::LEVEL_WIDTH-1:0];
                lms_pkg::REG_ALARM_ON_TICKS: cfg_reg.alarm_on_ticks     <= cfg_data;
                lms_pkg::REG_ALARM_OFF:      cfg_reg.alarm_off_ticks    <= cfg_data;
                default:                     cfg_reg.start_ticks        <= cfg_reg.start_ticks;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            btn_reg   <= button_pressed;
            lim_reg   <= limit_reached;
            level_reg <= battery_level;
        end
    end

    // Next state: resolve every hand-over of one tick
    always_comb
    begin
        lms_pkg::phase_t                ph;
        logic [lms_pkg::TICK_WIDTH-1:0] c;
        logic [lms_pkg::TICK_WIDTH-1:0] idle;
        logic                           closed;
        logic                           opening;
        logic                           sam;
        logic                           edge_live;
        logic                           low;
        logic [1:0]                     drive;
        lms_pkg::walk_t                 w1;
        lms_pkg::walk_t                 w2;

        ph        = phase_reg;
        c         = count_reg;
        idle      = idle_reg;
        closed    = closed_reg;
        opening   = opening_reg;
        sam       = sam_reg;
        drive     = lms_pkg::DRIVE_OFF;
        edge_live = btn_reg & ~btn_prev_reg;
        low       = (level_reg <= cfg_reg.battery_low_level) &&
                    (level_reg >= lms_pkg::BATTERY_FLOOR);

        // power up check, and recovery from a code outside the phase list
        case (ph) inside
            lms_pkg::PH_POWERUP:
            begin
                c = '0;
                if (lim_reg)
                begin
                    ph = lms_pkg::PH_SLEEP;
                end
                else
                begin
                    opening = 1'b0;
                    sam     = 1'b1;
                    ph      = lms_pkg::PH_START;
                end
            end
            lms_pkg::PH_IDLE, lms_pkg::PH_SLEEP, lms_pkg::PH_START, lms_pkg::PH_RUN,
            lms_pkg::PH_BOUNCE, lms_pkg::PH_STOP, lms_pkg::PH_ALARM_ON,
            lms_pkg::PH_ALARM_OFF:
            begin
                ph = phase_reg;
            end
            default:
            begin
                ph = lms_pkg::PH_IDLE;
                c  = '0;
            end
        endcase

        // move already under way
        w1 = lms_pkg::walk(ph, c, opening, lim_reg, cfg_reg);
        if (ph == lms_pkg::PH_START || ph == lms_pkg::PH_RUN ||
            ph == lms_pkg::PH_BOUNCE || ph == lms_pkg::PH_STOP)
        begin
            if (w1.finished)
            begin
                closed = ~opening;
                idle   = '0;
                c      = '0;
                if (sam)
                begin
                    sam = 1'b0;
                    ph  = lms_pkg::PH_SLEEP;
                end
                else
                begin
                    ph = lms_pkg::PH_IDLE;
                end
            end
            else
            begin
                ph    = w1.phase;
                c     = w1.count;
                drive = w1.drive;
            end
        end

        // new press while idle or asleep
        if ((ph == lms_pkg::PH_IDLE || ph == lms_pkg::PH_SLEEP) && edge_live)
        begin
            edge_live = 1'b0;
            idle      = '0;
            c         = '0;
            if (low)
            begin
                ph = lms_pkg::PH_ALARM_ON;
            end
            else
            begin
                opening = closed;
                sam     = 1'b0;
                ph      = lms_pkg::PH_START;
            end
        end

        // move started by that press
        w2 = lms_pkg::walk(lms_pkg::PH_START, '0, opening, lim_reg, cfg_reg);
        if (ph == lms_pkg::PH_START && !edge_live && c == '0 && drive == lms_pkg::DRIVE_OFF)
        begin
            if (w2.finished)
            begin
                closed = ~opening;
                idle   = '0;
                ph     = lms_pkg::PH_IDLE;
            end
            else
            begin
                ph    = w2.phase;
                c     = w2.count;
                drive = w2.drive;
            end
        end

        // idle tick count toward sleep
        if (ph == lms_pkg::PH_IDLE)
        begin
            idle = lms_pkg::bump(idle);
            if (lms_pkg::reached(idle, cfg_reg.idle_timeout_ticks))
            begin
                ph = lms_pkg::PH_SLEEP;
                c  = '0;
            end
        end

        // alarm blink
        if (ph == lms_pkg::PH_ALARM_ON)
        begin
            if (c != '0 && lms_pkg::reached(c, cfg_reg.alarm_on_ticks))
            begin
                ph = lms_pkg::PH_ALARM_OFF;
                c  = '0;
            end
            else
            begin
                drive = lms_pkg::DRIVE_OPEN;
            end
            c = lms_pkg::bump(c);
        end
        else if (ph == lms_pkg::PH_ALARM_OFF)
        begin
            if (c != '0 && lms_pkg::reached(c, cfg_reg.alarm_off_ticks))
            begin
                ph    = lms_pkg::PH_ALARM_ON;
                c     = '0;
                drive = lms_pkg::DRIVE_OPEN;
            end
            c = lms_pkg::bump(c);
        end

        phase_next   = ph;
        count_next   = c;
        idle_next    = idle;
        closed_next  = closed;
        opening_next = opening;
        sam_next     = sam;
        drive_next   = drive;
    end

    // Sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= lms_pkg::PH_POWERUP;
            count_reg    <= '0;
            idle_reg     <= '0;
            closed_reg   <= 1'b1;
            opening_reg  <= 1'b0;
            btn_prev_reg <= 1'b0;
            sam_reg      <= 1'b0;
        end
        else if (in_valid_reg && advance)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            idle_reg     <= idle_next;
            closed_reg   <= closed_next;
            opening_reg  <= opening_next;
            btn_prev_reg <= btn_reg;
            sam_reg      <= sam_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            drive_reg      <= drive_next;
            closed_out_reg <= closed_next;
            asleep_reg     <= (phase_next == lms_pkg::PH_SLEEP);
            alarm_reg      <= (phase_next == lms_pkg::PH_ALARM_ON) ||
                              (phase_next == lms_pkg::PH_ALARM_OFF);
        end
    end

    // Outputs
    always_comb
    begin
        out_valid     = out_valid_reg;
        motor_drive   = drive_reg;
        lid_closed    = closed_out_reg;
        asleep        = asleep_reg;
        battery_alarm = alarm_reg;
    end

endmodule
`default_nettype wire

>>> test/tb_lid_motor_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lid_motor_sequencer
// Self-checking bench for the lid motor sequencer.
// ----------------------------------------------------------------------------
// Tick words are queued per phase by the sequence block and driven by a
// clocked driver. Each accepted word is run through a local tick predictor
// that holds its own copy of the lid state and of the timing registers. The
// monitor checks every result word against the oldest prediction. Registers
// are reprogrammed only once the pipeline has drained. The phases run the reset
// timing, the shortest lengths, random settings, the longest lengths, a long
// start phase and finally the latched low battery alarm, which only reset
// clears.
// ----------------------------------------------------------------------------
module tb_lid_motor_sequencer;
    import lms_pkg::*;

    localparam int IDLE_PCT   = 26;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic       btn;
        logic       lim;
        logic [7:0] lvl;
    } tick_word_t;

    typedef struct packed {
        logic [1:0] drive;
        logic       closed;
        logic       sleeping;
        logic       alarm;
    } lid_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       button_pressed = 1'b0;
    logic       limit_reached = 1'b0;
    logic [7:0] battery_level = 8'd0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] motor_drive;
    logic       lid_closed;
    logic       asleep;
    logic       battery_alarm;

    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    // Stimulus and expectation stores
    tick_word_t  tick_q[$];
    lid_status_t status_q[$];
    logic        gen_btn = 1'b0;
    bit          calm = 1'b0;
    int unsigned mismatches = 0;
    int          quiet_cycles = 0;

    // Predictor state and register copy
    cfg_t            lid_cfg;
    phase_t          ph = PH_POWERUP;
    logic [15:0]     ph_cnt = '0;
    logic [15:0]     idle_cnt = '0;
    logic            lid_shut = 1'b1;
    logic            opening = 1'b0;
    logic            btn_prev = 1'b0;
    logic            sleep_after = 1'b0;

    lid_motor_sequencer dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .button_pressed (button_pressed),
        .limit_reached  (limit_reached),
        .battery_level  (battery_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .motor_drive    (motor_drive),
        .lid_closed     (lid_closed),
        .asleep         (asleep),
        .battery_alarm  (battery_alarm),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // Saturating tick counter
    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic void enter_phase(input phase_t p);
        ph     = p;
        ph_cnt = '0;
    endfunction

    // One tick of the lid sequencer; phases whose length is reached hand over
    // within the same tick
    function automatic lid_status_t step_lid(input logic btn, input logic lim,
                                             input logic [7:0] lvl);
        logic        rise;
        logic        settled;
        logic [1:0]  drv;
        logic [1:0]  fwd;
        logic [1:0]  rev;
        lid_status_t s;
        rise     = btn && !btn_prev;
        btn_prev = btn;
        drv      = DRIVE_OFF;
        settled  = 1'b0;
        while (!settled)
        begin
            fwd = opening ? DRIVE_OPEN : DRIVE_CLOSE;
            rev = opening ? DRIVE_CLOSE : DRIVE_OPEN;
            case (ph) inside
                PH_POWERUP:
                begin
                    if (lim)
                    begin
                        enter_phase(PH_SLEEP);
                    end
                    else
                    begin
                        opening     = 1'b0;
                        sleep_after = 1'b1;
                        enter_phase(PH_START);
                    end
                end
                PH_IDLE, PH_SLEEP:
                begin
                    if (rise)
                    begin
                        // press: battery check first, else toggle the lid
                        rise     = 1'b0;
                        idle_cnt = '0;
                        if (lvl <= lid_cfg.battery_low_level && lvl >= BATTERY_FLOOR)
                        begin
                            enter_phase(PH_ALARM_ON);
                        end
                        else
                        begin
                            opening     = lid_shut;
                            sleep_after = 1'b0;
                            enter_phase(PH_START);
                        end
                    end
                    else
                    begin
                        if (ph == PH_IDLE)
                        begin
                            idle_cnt = sat_inc(idle_cnt);
                            if (idle_cnt >= lid_cfg.idle_timeout_ticks)
                            begin
                                enter_phase(PH_SLEEP);
                            end
                        end
                        settled = 1'b1;
                    end
                end
                PH_START:
                begin
                    if (ph_cnt >= lid_cfg.start_ticks)
                    begin
                        enter_phase(PH_RUN);
                    end
                    else
                    begin
                        drv     = fwd;
                        ph_cnt  = sat_inc(ph_cnt);
                        settled = 1'b1;
                    end
                end
                PH_RUN:
                begin
                    if (lim || ph_cnt >= lid_cfg.run_timeout_ticks)
                    begin
                        enter_phase(PH_BOUNCE);
                    end
                    else
                    begin
                        drv     = fwd;
                        ph_cnt  = sat_inc(ph_cnt);
                        settled = 1'b1;
                    end
                end
                PH_BOUNCE:
                begin
                    if (ph_cnt >= lid_cfg.bounce_ticks)
                    begin
                        enter_phase(PH_STOP);
                    end
                    else
                    begin
                        drv     = rev;
                        ph_cnt  = sat_inc(ph_cnt);
                        settled = 1'b1;
                    end
                end
                PH_STOP:
                begin
                    if (ph_cnt >= lid_cfg.stop_ticks)
                    begin
                        // move complete: the lid flag follows its direction
                        lid_shut = !opening;
                        idle_cnt = '0;
                        if (sleep_after)
                        begin
                            sleep_after = 1'b0;
                            enter_phase(PH_SLEEP);
                        end
                        else
                        begin
                            enter_phase(PH_IDLE);
                        end
                    end
                    else
                    begin
                        ph_cnt  = sat_inc(ph_cnt);
                        settled = 1'b1;
                    end
                end
                PH_ALARM_ON:
                begin
                    if (ph_cnt >= 16'd1 && ph_cnt >= lid_cfg.alarm_on_ticks)
                    begin
                        enter_phase(PH_ALARM_OFF);
                    end
                    if (ph == PH_ALARM_ON)
                    begin
                        drv = DRIVE_OPEN;
                    end
                    ph_cnt  = sat_inc(ph_cnt);
                    settled = 1'b1;
                end
                PH_ALARM_OFF:
                begin
                    if (ph_cnt >= 16'd1 && ph_cnt >= lid_cfg.alarm_off_ticks)
                    begin
                        enter_phase(PH_ALARM_ON);
                        drv = DRIVE_OPEN;
                    end
                    ph_cnt  = sat_inc(ph_cnt);
                    settled = 1'b1;
                end
                default:
                begin
                    enter_phase(PH_IDLE);
                end
            endcase
        end
        s.drive    = drv;
        s.closed   = lid_shut;
        s.sleeping = (ph == PH_SLEEP);
        s.alarm    = (ph == PH_ALARM_ON || ph == PH_ALARM_OFF);
        return s;
    endfunction

    // Battery sample; a safe one never counts as low at the current threshold
    function automatic logic [7:0] pick_level(input bit safe);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (safe && v >= BATTERY_FLOOR && v <= lid_cfg.battery_low_level)
        begin
            if (lid_cfg.battery_low_level == 8'hFF || $urandom_range(0, 1) == 0)
            begin
                v = 8'($urandom_range(0, BATTERY_FLOOR - 1));
            end
            else
            begin
                v = 8'($urandom_range(lid_cfg.battery_low_level + 1, 255));
            end
        end
        return v;
    endfunction

    task automatic add_tick(input logic b, input logic l, input logic [7:0] v);
        gen_btn = b;
        tick_q.push_back('{b, l, v});
    endtask

    // Random ticks: presses held for a few ticks, sparse limit pulses
    task automatic queue_ticks(input int n, input int press_pct, input int lim_pct,
                               input bit safe);
        logic l;
        repeat (n)
        begin
            if (gen_btn)
            begin
                gen_btn = ($urandom_range(0, 99) < 60);
            end
            else
            begin
                gen_btn = ($urandom_range(0, 99) < press_pct);
            end
            l = ($urandom_range(0, 99) < lim_pct);
            tick_q.push_back('{gen_btn, l, pick_level(safe)});
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_START_TICKS:    lid_cfg.start_ticks        = val;
            REG_RUN_TIMEOUT:    lid_cfg.run_timeout_ticks  = val;
            REG_BOUNCE_TICKS:   lid_cfg.bounce_ticks       = val;
            REG_STOP_TICKS:     lid_cfg.stop_ticks         = val;
            REG_IDLE_TIMEOUT:   lid_cfg.idle_timeout_ticks = val;
            REG_BATTERY_LOW:    lid_cfg.battery_low_level  = val[7:0];
            REG_ALARM_ON_TICKS: lid_cfg.alarm_on_ticks     = val;
            REG_ALARM_OFF:      lid_cfg.alarm_off_ticks    = val;
            default:            ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] st, input logic [15:0] rt,
                                input logic [15:0] bt, input logic [15:0] sp,
                                input logic [15:0] it, input logic [7:0] lo,
                                input logic [15:0] ao, input logic [15:0] af);
        write_reg(REG_START_TICKS, st);
        write_reg(REG_RUN_TIMEOUT, rt);
        write_reg(REG_BOUNCE_TICKS, bt);
        write_reg(REG_STOP_TICKS, sp);
        write_reg(REG_IDLE_TIMEOUT, it);
        write_reg(REG_BATTERY_LOW, {8'd0, lo});
        write_reg(REG_ALARM_ON_TICKS, ao);
        write_reg(REG_ALARM_OFF, af);
    endtask

    // Hold the sender until every queued word is checked, plus the latency
    task automatic drain();
        while (tick_q.size() != 0 || status_q.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    // Driver: predicts each accepted word, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                status_q.push_back(step_lid(button_pressed, limit_reached, battery_level));
            end
            if (!in_valid || !in_stall)
            begin
                if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid       <= 1'b1;
                    button_pressed <= tick_q[0].btn;
                    limit_reached  <= tick_q[0].lim;
                    battery_level  <= tick_q[0].lvl;
                    void'(tick_q.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: result word with nothing expected", $realtime);
                    end
                end
                else if (motor_drive !== status_q[0].drive
                         || lid_closed !== status_q[0].closed
                         || asleep !== status_q[0].sleeping
                         || battery_alarm !== status_q[0].alarm)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: drive %0d/%0d closed %0b/%0b asleep %0b/%0b alarm %0b/%0b",
                                 $realtime, status_q[0].drive, motor_drive,
                                 status_q[0].closed, lid_closed,
                                 status_q[0].sleeping, asleep,
                                 status_q[0].alarm, battery_alarm);
                        $display("    (values shown as expected/actual)");
                    end
                end
                if (status_q.size() != 0)
                begin
                    void'(status_q.pop_front());
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("lid_motor_sequencer verification failed");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        lid_cfg = '{RST_START_TICKS, RST_RUN_TIMEOUT, RST_BOUNCE_TICKS, RST_STOP_TICKS,
                    RST_IDLE_TIMEOUT, RST_BATTERY_LOW, RST_ALARM_ON_TICKS, RST_ALARM_OFF};
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset timing, power up check on the first tick
        add_tick(1'b0, 1'($urandom_range(0, 1)), pick_level(1'b1));
        queue_ticks(100, 8, 3, 1'b1);
        drain();

        // shortest lengths, directed words first
        program_regs(16'd0, 16'd1, 16'd0, 16'd0, 16'd1, 8'd0, 16'd1, 16'd1);
        add_tick(1'b0, 1'b0, 8'h00);
        add_tick(1'b1, 1'b0, 8'h00);
        add_tick(1'b1, 1'b0, 8'hFF);
        add_tick(1'b0, 1'b1, 8'hFF);
        add_tick(1'b1, 1'b1, 8'h55);
        add_tick(1'b0, 1'b0, 8'hAA);
        add_tick(1'b0, 1'b0, 8'h00);
        add_tick(1'b1, 1'b0, 8'hFF);
        add_tick(1'b0, 1'b0, 8'h0F);
        add_tick(1'b1, 1'b1, 8'hF0);
        add_tick(1'b0, 1'b1, 8'h04);
        add_tick(1'b0, 1'b0, 8'h05);
        queue_ticks(80, 30, 20, 1'b1);
        drain();

        // random short settings, one of them without idling
        for (int k = 0; k < 4; k++)
        begin
            calm = (k == 1);
            program_regs(16'($urandom_range(0, 6)), 16'($urandom_range(1, 8)),
                         16'($urandom_range(0, 5)), 16'($urandom_range(0, 6)),
                         16'($urandom_range(1, 10)), 8'($urandom_range(0, 254)),
                         16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)));
            queue_ticks(100, 15, 10, 1'b1);
            drain();
        end
        calm = 1'b0;

        // longest lengths
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd254,
                     16'hFFFF, 16'hFFFF);
        queue_ticks(60, 15, 10, 1'b1);
        drain();

        // long start phase under a steady word stream
        calm = 1'b1;
        program_regs(16'hFFFF, 16'd2, 16'd1, 16'd1, 16'd3, 8'd4, 16'd1, 16'd1);
        repeat (10) add_tick(1'b0, 1'b0, pick_level(1'b1));
        add_tick(1'b1, 1'b0, pick_level(1'b1));
        queue_ticks(100, 0, 2, 1'b1);
        drain();
        calm = 1'b0;

        // every sample from the floor up is low: moves first, then the alarm
        program_regs(16'd1, 16'd3, 16'd1, 16'd2, 16'd4, 8'd255, 16'd3, 16'd2);
        repeat (20) add_tick(1'b0, 1'($urandom_range(0, 1)), pick_level(1'b1));
        queue_ticks(60, 25, 10, 1'b1);
        repeat (20) add_tick(1'b0, 1'($urandom_range(0, 1)), pick_level(1'b1));
        add_tick(1'b1, 1'b0, ($urandom_range(0, 1) == 0) ? BATTERY_FLOOR
                                                        : 8'($urandom_range(6, 255)));
        queue_ticks(80, 20, 20, 1'b0);
        drain();

        // latched alarm under different blink lengths
        write_reg(REG_ALARM_ON_TICKS, 16'hFFFF);
        write_reg(REG_ALARM_OFF, 16'd1);
        queue_ticks(40, 20, 20, 1'b0);
        drain();
        write_reg(REG_ALARM_ON_TICKS, 16'd1);
        write_reg(REG_ALARM_OFF, 16'hFFFF);
        queue_ticks(40, 20, 20, 1'b0);
        drain();
        write_reg(REG_ALARM_OFF, 16'd1);
        queue_ticks(60, 20, 20, 1'b0);
        drain();

        if (mismatches == 0)
        begin
            $display("lid_motor_sequencer verification clean");
        end
        else
        begin
            $display("lid_motor_sequencer verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/lms_pkg.sv
rtl/lid_motor_sequencer.sv
test/tb_lid_motor_sequencer.sv
